// ===== hdl/ncdf_pkg.sv =====
`default_nettype none

package ncdf_pkg;

    // Q.30 working format
    localparam int QBITS = 30;
    localparam logic [30:0] QONE = 31'(64'd1 << 30);

    // Polynomial and scale constants, rounded to Q.30
    localparam logic [27:0] COEF_B =
        28'((64'd2316419 * (64'd1 << 30) + 64'd5000000) / 64'd10000000);
    localparam logic [29:0] COEF_1 =
        30'((64'd31938153 * (64'd1 << 30) + 64'd50000000) / 64'd100000000);
    localparam logic [29:0] COEF_2 =
        30'((64'd356563782 * (64'd1 << 30) + 64'd500000000) / 64'd1000000000);
    localparam logic [30:0] COEF_3 =
        31'((64'd1781477937 * (64'd1 << 30) + 64'd500000000) / 64'd1000000000);
    localparam logic [30:0] COEF_4 =
        31'((64'd1821255978 * (64'd1 << 30) + 64'd500000000) / 64'd1000000000);
    localparam logic [30:0] COEF_5 =
        31'((64'd1330274429 * (64'd1 << 30) + 64'd500000000) / 64'd1000000000);
    localparam logic [29:0] LN_TWO =
        30'((64'd6931471806 * (64'd1 << 30) + 64'd5000000000) / 64'd10000000000);
    localparam logic [28:0] INV_ROOT_TAU =
        29'((64'd3989422804 * (64'd1 << 30) + 64'd5000000000) / 64'd10000000000);

    // Step counts of the iterative sections, and the reciprocal shift
    localparam int DIV_STEPS  = 31;
    localparam int RED_STEPS  = 6;
    localparam int EXP_TERMS  = 12;
    localparam int POLY_STEPS = 5;
    localparam int RECIP_SHIFT = 33;

    typedef logic signed [33:0] poly_t;

    // Constant added after each Horner multiply of the tail polynomial
    localparam poly_t POLY_ADD [POLY_STEPS] = '{
        -poly_t'(COEF_4),
        poly_t'(COEF_3),
        -poly_t'(COEF_2),
        poly_t'(COEF_1),
        poly_t'(0)
    };

endpackage

`default_nettype wire

// ===== hdl/normal_cdf_approximation_core.sv =====
`default_nettype none

// Standard normal CDF, one word in and one word out per cycle while no stall
// holds the flow. Input channel: in_valid / in_stall with z_value, signed
// Q4.(IN_WIDTH-4). Output channel: out_valid / out_stall with probability,
// unsigned Q0.OUT_WIDTH; 1.0 saturates to all ones.
// A word is taken on a clock edge where valid is high and stall is low.
// The pipeline length comes mainly from the 31-stage reciprocal divider, the
// ln 2 reduction (6 stages), the 12-term exponential series at three stages
// per term, and the five-step tail polynomial at two stages a step.
// A result held by out_stall moves into a skid register while the pipeline
// keeps going; in_stall rises only once that skid register is also full,
// and then the whole pipeline holds until the receiver takes a word.
// Reset clears all valid bits; nothing else needs clearing.
module normal_cdf_approximation_core #(
    parameter int IN_WIDTH  = 16,
    parameter int OUT_WIDTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [IN_WIDTH-1:0]  z_value,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [OUT_WIDTH-1:0]      probability
);

    localparam int HS    = 2 * IN_WIDTH - 37;
    localparam int PSTG  = 2 * ncdf_pkg::POLY_STEPS;

    logic en;

    // front stages
    logic                   v0_reg, v1_reg, v2_reg, v3_reg;
    logic [IN_WIDTH-1:0]    z0_reg;
    logic                   neg1_reg, neg2_reg, neg3_reg;
    logic [IN_WIDTH-1:0]    mag1_reg;
    logic [2*IN_WIDTH-1:0]  sq2_reg;
    logic [IN_WIDTH+27:0]   bm2_reg;
    logic [31:0]            den3_reg;
    logic [35:0]            half3_reg;
    logic [35:0]            half_next;
    logic [63:0]            sq_wide;

    // divider and exponential
    logic        rv;
    logic [30:0] rtq;
    logic [36:0] rside;
    logic        xv;
    logic [30:0] xex;
    logic [31:0] xside;

    // polynomial stages
    logic                 pv_valid_reg [PSTG];
    logic [30:0]          ptq_reg      [PSTG];
    logic [30:0]          pex_reg      [PSTG];
    logic                 pneg_reg     [PSTG];
    ncdf_pkg::poly_t      pv_w         [ncdf_pkg::POLY_STEPS];

    // tail scaling
    logic        t1v_reg, t2v_reg;
    logic        t1neg_reg, t2neg_reg;
    logic [32:0] pc;
    logic [63:0] tprod1;
    logic [61:0] tprod2;
    logic [32:0] term1_reg;
    logic [31:0] term2_reg;
    logic [30:0] term_sat;
    logic [30:0] vq;
    logic [63:0] round_w;
    logic [63:0] res_w;
    logic [OUT_WIDTH-1:0] res;

    // output register and skid
    logic                 out_valid_reg;
    logic [OUT_WIDTH-1:0] probability_reg;
    logic                 skid_valid_reg;
    logic [OUT_WIDTH-1:0] skid_reg;

    assign en = !skid_valid_reg;

    // valid bits of the front and back stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            t1v_reg <= 1'b0;
            t2v_reg <= 1'b0;
            for (int i = 0; i < PSTG; i++)
            begin
                pv_valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            pv_valid_reg[0] <= xv;
            for (int i = 1; i < PSTG; i++)
            begin
                pv_valid_reg[i] <= pv_valid_reg[i-1];
            end
            t1v_reg <= pv_valid_reg[PSTG-1];
            t2v_reg <= t1v_reg;
        end
    end

    // z squared over 2, scaled to Q.30
    assign sq_wide = 64'(sq2_reg);
    if (HS >= 0)
    begin : g_hs_right
        assign half_next = 36'(sq_wide >> HS);
    end
    else
    begin : g_hs_left
        assign half_next = 36'(sq_wide << (-HS));
    end

    // magnitude, square, denominator
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg    <= z_value;
            neg1_reg  <= z0_reg[IN_WIDTH-1];
            mag1_reg  <= z0_reg[IN_WIDTH-1] ? (-z0_reg) : z0_reg;
            neg2_reg  <= neg1_reg;
            sq2_reg   <= (2*IN_WIDTH)'(mag1_reg) * (2*IN_WIDTH)'(mag1_reg);
            bm2_reg   <= (IN_WIDTH+28)'(ncdf_pkg::COEF_B) * (IN_WIDTH+28)'(mag1_reg);
            neg3_reg  <= neg2_reg;
            den3_reg  <= 32'(ncdf_pkg::QONE) + 32'(bm2_reg >> (IN_WIDTH - 4));
            half3_reg <= half_next;
        end
    end

    ncdf_recip #(
        .SIDE_W (37)
    ) u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v3_reg),
        .den      (den3_reg),
        .side_in  ({half3_reg, neg3_reg}),
        .out_valid(rv),
        .tq       (rtq),
        .side_out (rside)
    );

    ncdf_exp #(
        .SIDE_W (32)
    ) u_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (rv),
        .x        (rside[36:1]),
        .side_in  ({rtq, rside[0]}),
        .out_valid(xv),
        .ex       (xex),
        .side_out (xside)
    );

    // tq, exponential and sign ride along the polynomial stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ptq_reg[0]  <= xside[31:1];
            pex_reg[0]  <= xex;
            pneg_reg[0] <= xside[0];
            for (int i = 1; i < PSTG; i++)
            begin
                ptq_reg[i]  <= ptq_reg[i-1];
                pex_reg[i]  <= pex_reg[i-1];
                pneg_reg[i] <= pneg_reg[i-1];
            end
        end
    end

    // tail polynomial, Horner with truncation toward zero
    for (genvar j = 0; j < ncdf_pkg::POLY_STEPS; j++)
    begin : g_poly
        ncdf_pkg::poly_t p_in;
        logic [30:0]     tq_in;
        logic [32:0]     pmag;
        logic [63:0]     prod;
        logic [33:0]     m_reg;
        logic            sg_reg;
        ncdf_pkg::poly_t p_reg;

        if (j == 0)
        begin : g_first
            assign p_in  = ncdf_pkg::poly_t'(ncdf_pkg::COEF_5);
            assign tq_in = xside[31:1];
        end
        else
        begin : g_next
            assign p_in  = pv_w[j-1];
            assign tq_in = ptq_reg[2*j-1];
        end

        always_comb
        begin
            pmag = p_in[33] ? 33'(-p_in) : 33'(p_in);
            prod = 64'(pmag) * 64'(tq_in);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg  <= prod[63:30];
                sg_reg <= p_in[33];
                p_reg  <= (sg_reg ? -$signed(m_reg) : $signed(m_reg))
                          + ncdf_pkg::POLY_ADD[j];
            end
        end

        assign pv_w[j] = p_reg;
    end

    // clamp, times exponential, times 1/sqrt(2 pi)
    always_comb
    begin
        pc     = pv_w[ncdf_pkg::POLY_STEPS-1][33] ? '0
                 : pv_w[ncdf_pkg::POLY_STEPS-1][32:0];
        tprod1 = 64'(pc) * 64'(pex_reg[PSTG-1]);
        tprod2 = 62'(term1_reg) * 62'(ncdf_pkg::INV_ROOT_TAU);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term1_reg <= tprod1[62:30];
            t1neg_reg <= pneg_reg[PSTG-1];
            term2_reg <= tprod2[61:30];
            t2neg_reg <= t1neg_reg;
        end
    end

    // saturate, mirror, round half up, saturate to output code
    always_comb
    begin
        term_sat = (term2_reg > 32'(ncdf_pkg::QONE)) ? ncdf_pkg::QONE : term2_reg[30:0];
        vq       = t2neg_reg ? term_sat : (ncdf_pkg::QONE - term_sat);
        round_w  = (64'(vq) << OUT_WIDTH) + (64'd1 << (ncdf_pkg::QBITS - 1));
        res_w    = round_w >> ncdf_pkg::QBITS;
        res      = ((res_w >> OUT_WIDTH) != 64'd0) ? '1 : res_w[OUT_WIDTH-1:0];
    end

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= t2v_reg;
            end
        end
        else if (t2v_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            probability_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (en && t2v_reg)
        begin
            skid_reg <= res;
        end
    end

    assign in_stall    = skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign probability = probability_reg;

endmodule

`default_nettype wire

// ===== hdl/ncdf_recip.sv =====
`default_nettype none

// Pipelined restoring divider: tq = 2^60 / den, one quotient bit per stage.
module ncdf_recip #(
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [31:0]       den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [30:0]            tq,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int N = ncdf_pkg::DIV_STEPS;

    logic              valid_reg [N];
    logic [SIDE_W-1:0] side_reg  [N];
    logic [31:0]       rem_w     [N];
    logic [31:0]       den_w     [N];
    logic [30:0]       q_w       [N];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < N; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // sideband rides along
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < N; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic [31:0] rem_in;
        logic [31:0] den_in;
        logic [30:0] q_in;
        logic [32:0] rem2;
        logic        fits;
        logic [31:0] rem_next;
        logic [31:0] rem_reg;
        logic [31:0] den_reg;
        logic [30:0] q_reg;

        if (i == 0)
        begin : g_first
            // numerator bits above the quotient range leave 2^29
            assign rem_in = 32'(64'd1 << 29);
            assign den_in = den;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_w[i-1];
            assign den_in = den_w[i-1];
            assign q_in   = q_w[i-1];
        end

        // shift, compare, subtract
        always_comb
        begin
            rem2     = {rem_in, 1'b0};
            fits     = (rem2 >= {1'b0, den_in});
            rem_next = fits ? 32'(rem2 - {1'b0, den_in}) : rem2[31:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                den_reg <= den_in;
                q_reg   <= {q_in[29:0], fits};
            end
        end

        assign rem_w[i] = rem_reg;
        assign den_w[i] = den_reg;
        assign q_w[i]   = q_reg;
    end

    assign out_valid = valid_reg[N-1];
    assign tq        = q_w[N-1];
    assign side_out  = side_reg[N-1];

endmodule

`default_nettype wire

// ===== hdl/ncdf_exp.sv =====
`default_nettype none

// exp(-x) in Q.30: reduction by ln 2 (one quotient bit per stage), then a
// 12-term Horner series (multiply, reciprocal multiply, correct), then the
// final shift by the reduction count.
module ncdf_exp #(
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [35:0]       x,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [30:0]            ex,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int RED   = ncdf_pkg::RED_STEPS;
    localparam int TERMS = ncdf_pkg::EXP_TERMS;
    localparam int N     = RED + 3 * TERMS + 1;

    logic              valid_reg [N];
    logic [SIDE_W-1:0] side_reg  [N];

    logic [35:0]     rx_w [RED];
    logic [RED-1:0]  rn_w [RED];
    logic [30:0]     acc_w [TERMS];
    logic [29:0]     rc_w  [TERMS];
    logic [RED-1:0]  nc_w  [TERMS];

    logic [30:0]     ex_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < N; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // sideband rides along
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < N; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // range reduction: n = x / ln2, remainder kept
    for (genvar i = 0; i < RED; i++)
    begin : g_red
        localparam int B = RED - 1 - i;
        localparam logic [35:0] STEP_C = 36'(ncdf_pkg::LN_TWO) << B;

        logic [35:0]    x_in;
        logic [RED-1:0] n_in;
        logic           fits;
        logic [35:0]    x_reg;
        logic [RED-1:0] n_reg;

        if (i == 0)
        begin : g_first
            assign x_in = x;
            assign n_in = '0;
        end
        else
        begin : g_next
            assign x_in = rx_w[i-1];
            assign n_in = rn_w[i-1];
        end

        assign fits = (x_in >= STEP_C);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg <= fits ? (x_in - STEP_C) : x_in;
                n_reg <= fits ? (n_in | RED'(1 << B)) : n_in;
            end
        end

        assign rx_w[i] = x_reg;
        assign rn_w[i] = n_reg;
    end

    // Horner: acc = 1 - ((r * acc) >> 30) / k, k from 12 down to 1
    for (genvar j = 0; j < TERMS; j++)
    begin : g_term
        localparam int K = TERMS - j;

        logic [30:0]    acc_in;
        logic [29:0]    r_in;
        logic [RED-1:0] n_in;
        logic [60:0]    prod;
        logic [29:0]    q0;
        logic [33:0]    qk;
        logic [33:0]    rem;
        logic [29:0]    q;

        logic [29:0]    pa_reg;
        logic [29:0]    ra_reg;
        logic [RED-1:0] na_reg;
        logic [29:0]    qb_reg;
        logic [29:0]    pb_reg;
        logic [29:0]    rb_reg;
        logic [RED-1:0] nb_reg;
        logic [30:0]    acc_reg;
        logic [29:0]    rc_reg;
        logic [RED-1:0] nc_reg;

        if (j == 0)
        begin : g_first
            assign acc_in = ncdf_pkg::QONE;
            assign r_in   = rx_w[RED-1][29:0];
            assign n_in   = rn_w[RED-1];
        end
        else
        begin : g_next
            assign acc_in = acc_w[j-1];
            assign r_in   = rc_w[j-1];
            assign n_in   = nc_w[j-1];
        end

        // quotient estimate: exact for k = 1, else reciprocal multiply
        if (K == 1)
        begin : g_unit
            assign q0 = pa_reg;
        end
        else
        begin : g_recip
            localparam logic [32:0] RECIP =
                33'((64'd1 << ncdf_pkg::RECIP_SHIFT) / K);
            logic [62:0] qprod;
            assign qprod = 63'(pa_reg) * 63'(RECIP);
            assign q0    = qprod[ncdf_pkg::RECIP_SHIFT +: 30];
        end

        // estimate is low by at most one
        always_comb
        begin
            prod = 61'(r_in) * 61'(acc_in);
            qk   = 34'(qb_reg) * 34'(K);
            rem  = 34'(pb_reg) - qk;
            q    = (rem >= 34'(K)) ? (qb_reg + 30'd1) : qb_reg;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_reg  <= prod[59:30];
                ra_reg  <= r_in;
                na_reg  <= n_in;
                qb_reg  <= q0;
                pb_reg  <= pa_reg;
                rb_reg  <= ra_reg;
                nb_reg  <= na_reg;
                acc_reg <= ncdf_pkg::QONE - {1'b0, q};
                rc_reg  <= rb_reg;
                nc_reg  <= nb_reg;
            end
        end

        assign acc_w[j] = acc_reg;
        assign rc_w[j]  = rc_reg;
        assign nc_w[j]  = nc_reg;
    end

    // scale by 2^-n; all-ones count means the value is gone
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg <= (nc_w[TERMS-1] == '1) ? '0 : (acc_w[TERMS-1] >> nc_w[TERMS-1]);
        end
    end

    assign out_valid = valid_reg[N-1];
    assign ex        = ex_reg;
    assign side_out  = side_reg[N-1];

endmodule

`default_nettype wire

// ===== sim/normal_cdf_approximation_core_tb.sv =====
`default_nettype none

module normal_cdf_approximation_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W  = 16;
    localparam int OUT_W = 16;
    localparam int QB = 30;
    localparam longint unsigned Q1 = 64'd1 << QB;
    localparam int LATENCY = 90;
    localparam int N_RANDOM = 550;
    localparam longint CYCLE_LIMIT = 400000;

    // Q.30 constants, rounded the same way as the block's
    localparam longint unsigned K_B  = (64'd2316419 * Q1 + 64'd5000000) / 64'd10000000;
    localparam longint unsigned K_1  = (64'd31938153 * Q1 + 64'd50000000) / 64'd100000000;
    localparam longint unsigned K_2  = (64'd356563782 * Q1 + 64'd500000000) / 64'd1000000000;
    localparam longint unsigned K_3  = (64'd1781477937 * Q1 + 64'd500000000) / 64'd1000000000;
    localparam longint unsigned K_4  = (64'd1821255978 * Q1 + 64'd500000000) / 64'd1000000000;
    localparam longint unsigned K_5  = (64'd1330274429 * Q1 + 64'd500000000) / 64'd1000000000;
    localparam longint unsigned K_LN2 =
        (64'd6931471806 * Q1 + 64'd5000000000) / 64'd10000000000;
    localparam longint unsigned K_IRT =
        (64'd3989422804 * Q1 + 64'd5000000000) / 64'd10000000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [IN_W-1:0] z_value;
    logic out_valid;
    logic out_stall;
    logic [OUT_W-1:0] probability;

    normal_cdf_approximation_core #(.IN_WIDTH(IN_W), .OUT_WIDTH(OUT_W)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .z_value(z_value),
        .out_valid(out_valid), .out_stall(out_stall), .probability(probability)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Signed Q.30 times unsigned Q.30, truncated toward zero
    function automatic longint mul_trunc(longint a, longint unsigned k);
        longint unsigned m;
        m = (a < 0) ? 64'(-a) : 64'(a);
        m = (m * k) >> QB;
        return (a < 0) ? -longint'(m) : longint'(m);
    endfunction

    // exp(-x), x in unsigned Q.30
    function automatic longint unsigned exp_decay(longint unsigned x);
        longint unsigned n, r, acc;
        n = x / K_LN2;
        r = x - n * K_LN2;
        acc = Q1;
        for (int k = 12; k >= 1; k--)
            acc = Q1 - ((r * acc) >> QB) / k;
        if (n >= 63)
            return 0;
        return acc >> n;
    endfunction

    function automatic logic [OUT_W-1:0] cdf_of(logic [IN_W-1:0] z);
        logic neg;
        longint unsigned mag, mag_q, half_sq, den, tq, ex, term, v, res;
        longint poly;
        neg = z[IN_W-1];
        mag = neg ? ((64'd1 << IN_W) - 64'(z)) : 64'(z);
        mag_q = mag << (QB - (IN_W - 4));
        half_sq = (mag * mag) << (QB - (2 * (IN_W - 4) + 1));
        den = Q1 + ((K_B * mag_q) >> QB);
        tq = (Q1 << QB) / den;
        poly = longint'(K_5);
        poly = mul_trunc(poly, tq) - longint'(K_4);
        poly = mul_trunc(poly, tq) + longint'(K_3);
        poly = mul_trunc(poly, tq) - longint'(K_2);
        poly = mul_trunc(poly, tq) + longint'(K_1);
        poly = mul_trunc(poly, tq);
        if (poly < 0)
            poly = 0;
        ex = exp_decay(half_sq);
        term = (64'(poly) * ex) >> QB;
        term = (term * K_IRT) >> QB;
        if (term > Q1)
            term = Q1;
        v = neg ? term : Q1 - term;
        res = ((v << OUT_W) + (64'd1 << (QB - 1))) >> QB;
        if (res > 64'hFFFF)
            res = 64'hFFFF;
        return OUT_W'(res);
    endfunction

    // Directed table: z and, where obvious, the expected probability
    typedef struct {
        logic [IN_W-1:0]  z;
        logic             known;
        logic [OUT_W-1:0] p;
    } z_row_t;

    localparam int N_DIR = 14;
    z_row_t dir_tab [N_DIR] = '{
        '{16'h0000, 1'b1, 16'h8000},   // z = 0 gives one half
        '{16'h8000, 1'b1, 16'h0000},   // most negative, taken as -8.0
        '{16'h7FFF, 1'b1, 16'hFFFF},   // largest positive saturates
        '{16'h8001, 1'b1, 16'h0000},
        '{16'h6000, 1'b1, 16'hFFFF},
        '{16'hA000, 1'b1, 16'h0000},   // large negative underflows
        '{16'h0001, 1'b0, 16'h0},
        '{16'hFFFF, 1'b0, 16'h0},
        '{16'h1000, 1'b0, 16'h0},
        '{16'hF000, 1'b0, 16'h0},
        '{16'h2000, 1'b0, 16'h0},
        '{16'hE000, 1'b0, 16'h0},
        '{16'h5555, 1'b0, 16'h0},
        '{16'hAAAA, 1'b0, 16'h0}
    };

    logic [OUT_W-1:0] expected_probs [$];
    int errors = 0;
    int results_seen = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    longint cycles = 0;

    // Receiver stall, refreshed at the falling edge
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Result check at the rising edge
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_probs.size() == 0)
            begin
                $error("unexpected word: probability=%0d", probability);
                errors++;
            end
            else
            begin
                if (probability !== expected_probs[0])
                begin
                    $error("probability mismatch: expected %0d actual %0d",
                           expected_probs[0], probability);
                    errors++;
                end
                void'(expected_probs.pop_front());
            end
        end
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one word and wait until it is taken; returns at a falling edge
    task automatic send_word(logic [IN_W-1:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        z_value <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_probs.push_back(cdf_of(z));
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_probs.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_phase(int n);
        logic [IN_W-1:0] z;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0: z = IN_W'($urandom);
                1: z = IN_W'($urandom_range(16'h3000));
                2: z = -IN_W'($urandom_range(16'h3000));
                default: z = IN_W'($urandom_range(16'h00FF)) ^ {IN_W{$urandom_range(1) == 1}};
            endcase
            send_word(z);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        z_value = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words, no idling
        for (int i = 0; i < N_DIR; i++)
        begin
            if (dir_tab[i].known && cdf_of(dir_tab[i].z) !== dir_tab[i].p)
            begin
                $error("table row %0d: expected %0d predicted %0d", i,
                       dir_tab[i].p, cdf_of(dir_tab[i].z));
                errors++;
            end
            send_word(dir_tab[i].z);
        end
        // Hold off until every directed result is back
        drain_results();

        send_idle_pct = 19;
        recv_idle_pct = 58;
        random_phase(N_RANDOM / 3);
        send_idle_pct = 58;
        recv_idle_pct = 19;
        random_phase(N_RANDOM / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(N_RANDOM - 2 * (N_RANDOM / 3));

        drain_results();
        repeat (LATENCY + 10) @(negedge clk);

        $display("covered %0d directed and %0d random arguments, %0d results checked",
                 N_DIR, N_RANDOM, results_seen);
        $display("idling: sender/receiver at 19/58, 58/19 and 0/0 percent");
        if (errors == 0 && expected_probs.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
